@@ sv/bdsl_pkg.sv @@
// shared types and constants for the button debounce and press detection block
package bdsl_pkg;

  localparam int NUM_BUTTONS = 3;
  localparam int TIME_BITS   = 32;
  localparam int BTN_W       = 2;
  localparam int MS_W        = 16;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  // raw pin level that means pressed
  localparam logic LOW = 1'b0;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SIMPLE = 2'd1,
    EV_LONG   = 2'd2
  } ev_kind_t;

  typedef enum logic [1:0] {
    REG_FILTER_MS     = 2'd0,
    REG_LONG_MS       = 2'd1,
    REG_SIMPLE_ENABLE = 2'd2,
    REG_LONG_ENABLE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic       fired_long;
    logic       fired_simple;
  } fired_t;

  typedef struct packed {
    logic       last_level;
    time_t      change_time;
    fired_t     fired;
  } lane_state_t;

  typedef struct packed {
    logic       raised;
    ev_kind_t   kind;
  } lane_ev_t;

endpackage

@@ sv/bdsl_lane.sv @@
// one button lane: settle check, simple and long press detection, state update
module bdsl_lane (
  input  logic                     lvl,
  input  bdsl_pkg::time_t          tick,
  input  logic [bdsl_pkg::MS_W-1:0] filter_ms,
  input  logic [bdsl_pkg::MS_W-1:0] long_ms,
  input  logic                     has_simple,
  input  logic                     has_long,
  input  bdsl_pkg::lane_state_t    cur,
  output bdsl_pkg::lane_state_t    nxt,
  output bdsl_pkg::lane_ev_t       ev
);

  bdsl_pkg::time_t   elapsed;
  logic              settled;
  logic              long_due;
  logic              was_pressed;
  logic              fire_simple;
  logic              fire_long;
  bdsl_pkg::fired_t  fired_nxt;

  assign elapsed     = tick - cur.change_time;
  assign settled     = elapsed >= bdsl_pkg::time_t'(filter_ms);
  assign long_due    = elapsed >= bdsl_pkg::time_t'(long_ms);
  assign was_pressed = cur.last_level == bdsl_pkg::LOW;

  // with a long action the simple event waits for the release
  assign fire_simple = settled && was_pressed && !cur.fired.fired_simple &&
                       (lvl != bdsl_pkg::LOW || !has_long);
  assign fire_long   = settled && was_pressed && !cur.fired.fired_long && long_due;

  always_comb begin
    fired_nxt = cur.fired;
    if (settled && !was_pressed) begin
      fired_nxt = '0;
    end
    if (fire_simple) begin
      fired_nxt.fired_simple = 1'b1;
    end
    if (fire_long) begin
      fired_nxt.fired_simple = 1'b1;
      fired_nxt.fired_long   = 1'b1;
    end
  end

  always_comb begin
    nxt.last_level  = lvl;
    nxt.change_time = (cur.last_level != lvl) ? tick : cur.change_time;
    nxt.fired       = fired_nxt;
  end

  always_comb begin
    ev.raised = fire_simple || fire_long;
    if (fire_long) begin
      ev.kind = has_long ? bdsl_pkg::EV_LONG : bdsl_pkg::EV_NONE;
    end else begin
      ev.kind = has_simple ? bdsl_pkg::EV_SIMPLE : bdsl_pkg::EV_NONE;
    end
  end

endmodule

@@ sv/bdsl_merge.sv @@
// merges lane events: the highest lane that raised one wins, even a silent one
module bdsl_merge (
  input  bdsl_pkg::lane_ev_t             ev [bdsl_pkg::NUM_BUTTONS],
  output bdsl_pkg::ev_kind_t             event_kind,
  output logic [bdsl_pkg::BTN_W-1:0]     event_button
);

  always_comb begin
    event_kind   = bdsl_pkg::EV_NONE;
    event_button = '0;
    for (int i = 0; i < bdsl_pkg::NUM_BUTTONS; i++) begin
      if (ev[i].raised) begin
        event_kind   = ev[i].kind;
        event_button = (ev[i].kind != bdsl_pkg::EV_NONE) ?
                       bdsl_pkg::BTN_W'(i) : '0;
      end
    end
  end

endmodule

@@ sv/button_debounce_short_long_press_unit.sv @@
// top level: debounce with simple and long press detection for three buttons
//
// Each input beat is one millisecond tick carrying the raw active-low pin
// levels of three buttons (in_pin_levels, valid/ready). Every tick gives
// exactly one result beat: the event raised (none, simple, long) and its
// button, the raw pressed mask, and the ticks since the mask last changed,
// shown on out_idle_ticks when nothing is pressed, else on out_held_ticks.
// Three lanes, one per button, evaluate a tick side by side and a merge
// stage keeps the last event raised; the whole step is combinational.
// A result beat comes in the cycle after its tick; throughput is one beat
// per cycle while the receiver keeps up. The result sits in an output
// register: a new tick is taken in the same cycle the held result is
// taken, so a stalled receiver stalls the input only while its result waits.
// Reset (rst_n low, synchronous) clears the tick counter and times, marks
// all buttons released, clears the fired flags and loads the register
// defaults: filter 50, long 2000, no actions enabled.
// Registers sit on the APB port at byte offsets 0, 4, 8 and 12 and are to be
// written only while no tick is in flight; the block does not enforce this.
module button_debounce_short_long_press_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bdsl_pkg::NUM_BUTTONS-1:0]   in_pin_levels,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_event_kind,
  output logic [bdsl_pkg::BTN_W-1:0]         out_event_button,
  output logic [bdsl_pkg::NUM_BUTTONS-1:0]   out_pressed_mask,
  output logic [bdsl_pkg::TIME_BITS-1:0]     out_idle_ticks,
  output logic [bdsl_pkg::TIME_BITS-1:0]     out_held_ticks,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bdsl_pkg::ADDR_W-1:0]        paddr,
  input  logic [bdsl_pkg::DATA_W-1:0]        pwdata,
  output logic [bdsl_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int NB = bdsl_pkg::NUM_BUTTONS;

  // configuration
  logic [bdsl_pkg::MS_W-1:0] filter_ms_r;
  logic [bdsl_pkg::MS_W-1:0] long_ms_r;
  logic [NB-1:0]             simple_en_r;
  logic [NB-1:0]             long_en_r;
  logic                      cfg_wr;
  bdsl_pkg::reg_idx_t        cfg_idx;

  // tick state
  bdsl_pkg::time_t           tick_r;
  bdsl_pkg::time_t           tick_nxt;
  bdsl_pkg::lane_state_t     lane_r   [NB];
  bdsl_pkg::lane_state_t     lane_nxt [NB];
  bdsl_pkg::lane_ev_t        lane_ev  [NB];
  logic [NB-1:0]             mask_r;
  logic [NB-1:0]             mask_nxt;
  bdsl_pkg::time_t           mask_time_r;
  bdsl_pkg::time_t           mask_time_nxt;
  bdsl_pkg::time_t           span;
  bdsl_pkg::ev_kind_t        ev_kind;
  logic [bdsl_pkg::BTN_W-1:0] ev_btn;

  // output register
  logic                      out_valid_r;
  logic [1:0]                ev_kind_r;
  logic [bdsl_pkg::BTN_W-1:0] ev_btn_r;
  logic [NB-1:0]             out_mask_r;
  bdsl_pkg::time_t           idle_r;
  bdsl_pkg::time_t           held_r;

  logic                      accept;

  // apb port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = bdsl_pkg::reg_idx_t'(paddr[3:2]);

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      bdsl_pkg::REG_FILTER_MS:     prdata = bdsl_pkg::DATA_W'(filter_ms_r);
      bdsl_pkg::REG_LONG_MS:       prdata = bdsl_pkg::DATA_W'(long_ms_r);
      bdsl_pkg::REG_SIMPLE_ENABLE: prdata = bdsl_pkg::DATA_W'(simple_en_r);
      bdsl_pkg::REG_LONG_ENABLE:   prdata = bdsl_pkg::DATA_W'(long_en_r);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_ms_r <= bdsl_pkg::MS_W'(50);
      long_ms_r   <= bdsl_pkg::MS_W'(2000);
      simple_en_r <= '0;
      long_en_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        bdsl_pkg::REG_FILTER_MS:     filter_ms_r <= pwdata[bdsl_pkg::MS_W-1:0];
        bdsl_pkg::REG_LONG_MS:       long_ms_r   <= pwdata[bdsl_pkg::MS_W-1:0];
        bdsl_pkg::REG_SIMPLE_ENABLE: simple_en_r <= pwdata[NB-1:0];
        bdsl_pkg::REG_LONG_ENABLE:   long_en_r   <= pwdata[NB-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the output register frees up in the cycle its beat is taken
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign tick_nxt = tick_r + bdsl_pkg::time_t'(1);

  for (genvar g = 0; g < NB; g++) begin : g_lane
    bdsl_lane u_lane (
      .lvl        (in_pin_levels[g]),
      .tick       (tick_nxt),
      .filter_ms  (filter_ms_r),
      .long_ms    (long_ms_r),
      .has_simple (simple_en_r[g]),
      .has_long   (long_en_r[g]),
      .cur        (lane_r[g]),
      .nxt        (lane_nxt[g]),
      .ev         (lane_ev[g])
    );
  end

  bdsl_merge u_merge (
    .ev           (lane_ev),
    .event_kind   (ev_kind),
    .event_button (ev_btn)
  );

  assign mask_nxt      = ~in_pin_levels;
  assign mask_time_nxt = (mask_nxt != mask_r) ? tick_nxt : mask_time_r;
  assign span          = tick_nxt - mask_time_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      mask_r      <= '0;
      mask_time_r <= '0;
      for (int i = 0; i < NB; i++) begin
        lane_r[i].last_level  <= 1'b1;
        lane_r[i].change_time <= '0;
        lane_r[i].fired       <= '0;
      end
    end else if (accept) begin
      tick_r      <= tick_nxt;
      mask_r      <= mask_nxt;
      mask_time_r <= mask_time_nxt;
      for (int i = 0; i < NB; i++) begin
        lane_r[i] <= lane_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ev_kind_r  <= ev_kind;
      ev_btn_r   <= ev_btn;
      out_mask_r <= mask_nxt;
      idle_r     <= (mask_nxt == '0) ? span : '0;
      held_r     <= (mask_nxt != '0) ? span : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = ev_kind_r;
  assign out_event_button = ev_btn_r;
  assign out_pressed_mask = out_mask_r;
  assign out_idle_ticks   = idle_r;
  assign out_held_ticks   = held_r;

endmodule
